[rtl/pidsfd_pkg.sv]
`timescale 1ns / 1ps
package pidsfd_pkg;

	localparam int DIV_W = 48;
	localparam int CNT_W = 6;
	localparam logic [16:0] Q_ONE = 17'h10000;
	localparam logic [30:0] CLAMP_RST = 31'd26214400;

	localparam logic [2:0] REG_GAIN_P = 3'd0;
	localparam logic [2:0] REG_GAIN_I = 3'd1;
	localparam logic [2:0] REG_GAIN_D = 3'd2;
	localparam logic [2:0] REG_ALPHA = 3'd3;
	localparam logic [2:0] REG_CLAMP = 3'd4;

	localparam logic [1:0] FN_FILT = 2'd0;
	localparam logic [1:0] FN_HIST = 2'd1;
	localparam logic [1:0] FN_CLEAR = 2'd2;
	localparam logic [1:0] FN_NONE = 2'd3;

	typedef struct packed {
		logic [1:0] func;
		logic signed [31:0] error_in;
		logic signed [31:0] measured;
		logic signed [31:0] given_prev_error;
		logic signed [31:0] given_prev_integral;
		logic [31:0] time_step;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] drive;
		logic signed [31:0] integral_now;
	} res_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		begin
			hi = 66'sh0_7FFF_FFFF;
			lo = -66'sh0_8000_0000;
			if (v > hi) sat32 = 32'sh7FFF_FFFF;
			else if (v < lo) sat32 = 32'sh8000_0000;
			else sat32 = v[31:0];
		end
	endfunction

	function automatic logic signed [31:0] clampl(input logic signed [31:0] v,
		input logic [30:0] lim);
		logic signed [32:0] l;
		logic signed [32:0] w;
		begin
			l = $signed({2'b00, lim});
			w = 33'(v);
			if (w > l) clampl = l[31:0];
			else if (w < -l) clampl = 32'(-l);
			else clampl = v;
		end
	endfunction

endpackage

[rtl/pid_step_filtered_derivative.sv]
`timescale 1ns / 1ps
// Modes 0 and 1 run the P, I and D steps and the bit-serial divider (skipped with a zero
// time step) and, in mode 0 only, the filter; a clear or unused mode skips to the result.
// A word is taken only once the last result is registered out; res_stall can hold it.
// The shared 33x33 multiplier is used six times in sequence in mode 0, four in mode 1.
// Reset: asynchronous, active low; history cleared, registers to defaults.
module pid_step_filtered_derivative
	import pidsfd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_stall,
	input cmd_t cmd,
	output logic res_valid,
	input logic res_stall,
	output res_t res,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_P = 4'd1;
	localparam logic [3:0] S_KI = 4'd2;
	localparam logic [3:0] S_INC = 4'd3;
	localparam logic [3:0] S_INC2 = 4'd4;
	localparam logic [3:0] S_KD = 4'd5;
	localparam logic [3:0] S_DIVST = 4'd6;
	localparam logic [3:0] S_DIV = 4'd7;
	localparam logic [3:0] S_FA = 4'd8;
	localparam logic [3:0] S_FB = 4'd9;
	localparam logic [3:0] S_FC = 4'd10;
	localparam logic [3:0] S_SUM = 4'd11;
	localparam logic [3:0] S_DONE = 4'd12;

	logic [3:0] state_q;
	cmd_t cmd_q;
	logic signed [31:0] gain_p_q, gain_i_q, gain_d_q;
	logic [16:0] alpha_q;
	logic [30:0] clamp_q;
	logic signed [31:0] last_err_q, last_meas_q, integ_acc_q, dfilt_q;
	logic signed [31:0] p_q, t_q, i_q, raw_q, d_q, drv_q, inow_q;
	logic signed [33:0] acc_q;
	logic signed [32:0] kn_q;
	logic signed [65:0] prod_q;
	logic signed [32:0] mul_a, mul_b;
	logic res_valid_q;
	res_t res_q;

	logic mode0;
	logic signed [31:0] pe, base, xv, xp, s_sum, d_diff, inc, sh16;
	logic [16:0] a_eff, a_inv;
	logic div_start, div_busy;
	logic [DIV_W-1:0] div_num, div_quot;
	logic [31:0] kmag;
	logic signed [DIV_W:0] q_signed;
	logic signed [33:0] tot;
	logic signed [31:0] kd;
	logic signed [32:0] kn;

	assign mode0 = (cmd_q.func == FN_FILT);
	assign pe = mode0 ? last_err_q : cmd_q.given_prev_error;
	assign base = mode0 ? integ_acc_q : cmd_q.given_prev_integral;
	assign xv = mode0 ? cmd_q.measured : cmd_q.error_in;
	assign xp = mode0 ? last_meas_q : cmd_q.given_prev_error;
	assign s_sum = sat32(66'(cmd_q.error_in) + 66'(pe));
	assign d_diff = sat32(66'(xv) - 66'(xp));
	assign sh16 = sat32(prod_q >>> 16);
	assign inc = sat32(prod_q >>> 17);
	assign kd = sh16;
	assign kn = mode0 ? -33'(kd) : 33'(kd);
	assign a_eff = (alpha_q > Q_ONE) ? Q_ONE : alpha_q;
	assign a_inv = Q_ONE - a_eff;
	assign kmag = kn[32] ? 32'(-kn) : kn[31:0];
	assign div_num = {kmag, 16'b0};
	assign div_start = (state_q == S_DIVST);
	assign q_signed = kn_q[32] ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
	assign tot = 34'(p_q) + 34'(i_q) + 34'(d_q);

	pidsfd_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(cmd_q.time_step),
		.busy(div_busy),
		.quot(div_quot)
	);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_P: begin
				mul_a = 33'(gain_p_q);
				mul_b = 33'(cmd_q.error_in);
			end
			S_KI: begin
				mul_a = 33'(gain_i_q);
				mul_b = 33'(s_sum);
			end
			S_INC2: begin
				mul_a = 33'(t_q);
				mul_b = $signed({1'b0, cmd_q.time_step});
			end
			S_KD: begin
				mul_a = 33'(gain_d_q);
				mul_b = 33'(d_diff);
			end
			S_FA: begin
				mul_a = $signed({16'b0, a_eff});
				mul_b = 33'(raw_q);
			end
			S_FB: begin
				mul_a = $signed({16'b0, a_inv});
				mul_b = 33'(dfilt_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 66'(mul_a) * 66'(mul_b);
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			alpha_q <= Q_ONE;
			clamp_q <= CLAMP_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GAIN_P: gain_p_q <= cfg_data;
				REG_GAIN_I: gain_i_q <= cfg_data;
				REG_GAIN_D: gain_d_q <= cfg_data;
				REG_ALPHA: alpha_q <= cfg_data[16:0];
				REG_CLAMP: clamp_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_valid_q <= 1'b0;
			last_err_q <= '0;
			last_meas_q <= '0;
			integ_acc_q <= '0;
			dfilt_q <= '0;
		end else begin
			if (state_q == S_DONE && (!res_valid_q || !res_stall)) res_valid_q <= 1'b1;
			else if (res_valid_q && !res_stall) res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						if (cmd.func == FN_FILT || cmd.func == FN_HIST) begin
							state_q <= S_P;
						end else begin
							drv_q <= '0;
							inow_q <= '0;
							if (cmd.func == FN_CLEAR) begin
								last_err_q <= '0;
								last_meas_q <= '0;
								integ_acc_q <= '0;
								dfilt_q <= '0;
							end
							state_q <= S_DONE;
						end
					end
				end
				S_P: state_q <= S_KI;
				S_KI: begin
					p_q <= sh16;
					state_q <= S_INC;
				end
				S_INC: begin
					t_q <= sh16;
					state_q <= S_INC2;
				end
				S_INC2: state_q <= S_KD;
				S_KD: begin
					i_q <= clampl(sat32(66'(base) + 66'(inc)), clamp_q);
					raw_q <= '0;
					if (cmd_q.time_step == '0) state_q <= mode0 ? S_FA : S_SUM;
					else state_q <= S_DIVST;
					d_q <= '0;
				end
				S_DIVST: begin
					kn_q <= kn;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (!div_busy && !div_start) begin
						raw_q <= sat32(66'(q_signed));
						d_q <= sat32(66'(q_signed));
						state_q <= mode0 ? S_FA : S_SUM;
					end
				end
				S_FA: state_q <= S_FB;
				S_FB: begin
					acc_q <= 34'(prod_q >>> 16);
					state_q <= S_FC;
				end
				S_FC: begin
					d_q <= sat32(66'(acc_q) + (prod_q >>> 16));
					state_q <= S_SUM;
				end
				S_SUM: begin
					drv_q <= clampl(sat32(66'(tot)), clamp_q);
					inow_q <= i_q;
					integ_acc_q <= i_q;
					last_err_q <= cmd_q.error_in;
					if (mode0) begin
						last_meas_q <= cmd_q.measured;
						dfilt_q <= d_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!res_valid_q || !res_stall) begin
						res_q.drive <= drv_q;
						res_q.integral_now <= inow_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

[rtl/pidsfd_div.sv]
`timescale 1ns / 1ps
module pidsfd_div
	import pidsfd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [DIV_W-1:0] num,
	input logic [31:0] den,
	output logic busy,
	output logic [DIV_W-1:0] quot
);

	logic [DIV_W-1:0] n_q;
	logic [31:0] r_q;
	logic [31:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic [32:0] shifted;
	logic [33:0] trial;

	assign shifted = {r_q, n_q[DIV_W-1]};
	assign trial = {1'b0, shifted} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			r_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[33]) begin
				r_q <= trial[31:0];
				n_q <= {n_q[DIV_W-2:0], 1'b1};
			end else begin
				r_q <= shifted[31:0];
				n_q <= {n_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quot = n_q;

endmodule

[verif/tb_pid_step_filtered_derivative.sv]
`timescale 1ns / 1ps
module tb_pid_step_filtered_derivative;
	import pidsfd_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	logic signed [31:0] kp_m, ki_m, kd_m;
	logic [16:0] alpha_m;
	logic [30:0] limit_m;
	logic signed [31:0] prev_err_m, prev_meas_m, integ_m, dfilt_m;

	res_t expected_out[$];
	int errors = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit quiet = 1'b0;

	pid_step_filtered_derivative i_dut (.*);

	always #4 clk = ~clk;

	function automatic longint sat(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return sat((a * b) >>> 16);
	endfunction

	function automatic longint clamp_lim(longint v);
		longint l;
		l = longint'({33'b0, limit_m});
		if (v > l) return l;
		if (v < -l) return -l;
		return v;
	endfunction

	function automatic longint integrate(longint base, longint e, longint pe,
		logic [31:0] dt);
		longint s, k, inc;
		s = sat(e + pe);
		k = qmul(longint'(ki_m), s);
		inc = sat((k * longint'({32'b0, dt})) >>> 17);
		return clamp_lim(sat(base + inc));
	endfunction

	function automatic longint derivative(longint x, longint xp, logic [31:0] dt,
		bit neg);
		longint d, k;
		if (dt == 0) return 0;
		d = sat(x - xp);
		k = qmul(longint'(kd_m), d);
		if (neg) k = -k;
		return sat((k * 65536) / longint'({32'b0, dt}));
	endfunction

	function automatic res_t pid_predict(cmd_t c);
		res_t r;
		longint e, p, ig, dt_term, raw, a;
		r = '0;
		e = longint'(c.error_in);
		if (c.func == FN_FILT) begin
			a = (alpha_m > Q_ONE) ? 65536 : longint'(alpha_m);
			p = qmul(longint'(kp_m), e);
			ig = integrate(longint'(integ_m), e, longint'(prev_err_m), c.time_step);
			raw = derivative(longint'(c.measured), longint'(prev_meas_m), c.time_step, 1);
			dt_term = sat(((a * raw) >>> 16) + (((65536 - a) * longint'(dfilt_m)) >>> 16));
			integ_m = ig[31:0];
			dfilt_m = dt_term[31:0];
			prev_err_m = c.error_in;
			prev_meas_m = c.measured;
			r.drive = 32'(clamp_lim(sat(p + ig + dt_term)));
			r.integral_now = ig[31:0];
		end else if (c.func == FN_HIST) begin
			p = qmul(longint'(kp_m), e);
			ig = integrate(longint'(c.given_prev_integral), e,
				longint'(c.given_prev_error), c.time_step);
			dt_term = derivative(e, longint'(c.given_prev_error), c.time_step, 0);
			integ_m = ig[31:0];
			prev_err_m = c.error_in;
			r.drive = 32'(clamp_lim(sat(p + ig + dt_term)));
			r.integral_now = ig[31:0];
		end else if (c.func == FN_CLEAR) begin
			prev_err_m = '0;
			prev_meas_m = '0;
			integ_m = '0;
			dfilt_m = '0;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0d want %0d at %0t", what, $signed(got),
			$signed(want), $realtime);
	endtask

	always @(posedge clk) begin
		res_t want;
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
		if (arst_n && res_valid && !res_stall) begin
			if (expected_out.size() == 0) begin
				report_mismatch("unexpected word", res.drive, 32'd0);
			end else begin
				want = expected_out.pop_front();
				if (res.drive !== want.drive) report_mismatch("drive", res.drive, want.drive);
				if (res.integral_now !== want.integral_now)
					report_mismatch("integral_now", res.integral_now, want.integral_now);
			end
		end
	end

	always @(negedge clk) begin
		if (quiet) begin
			res_stall = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			res_stall = 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 9) - 1;
			res_stall = 1'b1;
		end else begin
			res_stall = 1'b0;
		end
	end

	task automatic wait_drained();
		while (expected_out.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_GAIN_P: kp_m = value;
			REG_GAIN_I: ki_m = value;
			REG_GAIN_D: kd_m = value;
			REG_ALPHA: alpha_m = value[16:0];
			REG_CLAMP: limit_m = value[30:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_all(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
		logic [31:0] alpha, logic [31:0] lim);
		wait_drained();
		write_reg(REG_GAIN_P, kp);
		write_reg(REG_GAIN_I, ki);
		write_reg(REG_GAIN_D, kd);
		write_reg(REG_ALPHA, alpha);
		write_reg(REG_CLAMP, lim);
	endtask

	// hold the word until accepted, then predict; valid stays high for the next word
	task automatic send_word(cmd_t c);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			cmd_valid = 1'b0;
			repeat ($urandom_range(1, 9) - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd_valid = 1'b1;
		cmd = c;
		do @(posedge clk); while (cmd_stall);
		expected_out.push_back(pid_predict(c));
	endtask

	task automatic drop_valid();
		@(negedge clk);
		cmd_valid = 1'b0;
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
		endcase
	endfunction

	function automatic logic [31:0] rand_dt();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return $urandom();
			2: return 32'hFFFF_FFFF;
			default: return $urandom_range(1, 32'h0002_0000);
		endcase
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int pick;
		pick = $urandom_range(0, 99);
		c.func = (pick < 45) ? FN_FILT : (pick < 82) ? FN_HIST : (pick < 95) ? FN_CLEAR : FN_NONE;
		c.error_in = rand_word();
		c.measured = rand_word();
		c.given_prev_error = rand_word();
		c.given_prev_integral = rand_word();
		c.time_step = rand_dt();
		return c;
	endfunction

	function automatic cmd_t mk(logic [1:0] f, logic [31:0] e, logic [31:0] m,
		logic [31:0] pe, logic [31:0] pi, logic [31:0] dt);
		cmd_t c;
		c.func = f;
		c.error_in = e;
		c.measured = m;
		c.given_prev_error = pe;
		c.given_prev_integral = pi;
		c.time_step = dt;
		return c;
	endfunction

	task automatic test_reset_defaults();
		send_word(mk(FN_FILT, 32'h0001_0000, 32'h0002_0000, 0, 0, 32'h0000_1000));
		send_word(mk(FN_HIST, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000));
		drop_valid();
	endtask

	task automatic test_directed_extremes();
		set_all(32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'h0000_4000, {1'b0, CLAMP_RST});
		send_word(mk(FN_FILT, 32'h0001_0000, 32'h0000_8000, 0, 0, 32'h0000_0400));
		send_word(mk(FN_FILT, 32'h0002_0000, 32'h0001_0000, 0, 0, 32'h0000_0400));
		send_word(mk(FN_FILT, 32'h0002_0000, 32'h0003_0000, 0, 0, 32'h0000_0000));
		send_word(mk(FN_FILT, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'hFFFF_FFFF));
		send_word(mk(FN_FILT, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1));
		send_word(mk(FN_HIST, 32'h0001_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1));
		send_word(mk(FN_HIST, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000));
		send_word(mk(FN_HIST, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0010_0000,
			32'h0001_0000));
		send_word(mk(FN_FILT, 32'h0000_1000, 32'h0000_2000, 0, 0, 32'h0000_8000));
		send_word(mk(FN_NONE, 32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			32'hFFFF_FFFF));
		send_word(mk(FN_FILT, 32'h0000_1000, 32'h0000_3000, 0, 0, 32'h0000_8000));
		send_word(mk(FN_CLEAR, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'hFFFF_FFFF));
		send_word(mk(FN_FILT, 32'h0000_1000, 32'h0000_3000, 0, 0, 32'h0000_8000));
		drop_valid();
		// alpha above one saturates, clamp at zero pins everything
		set_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_FFFF, 32'd0);
		send_word(mk(FN_FILT, 32'h0100_0000, 32'hFF00_0000, 0, 0, 32'd1));
		send_word(mk(FN_HIST, 32'h8000_0000, 0, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF));
		drop_valid();
		set_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
		send_word(mk(FN_FILT, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 32'd1));
		send_word(mk(FN_FILT, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'hFFFF_FFFF));
		send_word(mk(FN_HIST, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1));
		drop_valid();
	endtask

	task automatic test_random_phases();
		logic [31:0] kp, ki, kd, alpha, lim;
		for (int ph = 0; ph < 6; ph++) begin
			kp = ($urandom_range(0, 3) == 0) ? $urandom() : rand_word();
			ki = ($urandom_range(0, 3) == 0) ? $urandom() : rand_word();
			kd = ($urandom_range(0, 3) == 0) ? $urandom() : rand_word();
			alpha = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17'h1FFFF)
				: $urandom_range(0, 32'h10000);
			lim = ($urandom_range(0, 3) == 0) ? $urandom() & 32'h7FFF_FFFF
				: $urandom_range(0, 32'h0400_0000);
			set_all(kp, ki, kd, alpha, lim);
			for (int n = 0; n < 80; n++) begin
				if (ph == 2 && n == 40) begin
					drop_valid();
					while (expected_out.size() != 0) @(posedge clk);
				end
				send_word(rand_cmd());
			end
			drop_valid();
		end
	endtask

	task automatic test_back_to_back();
		set_all(32'h0000_C000, 32'h0000_4000, 32'h0000_2000, 32'h0000_8000, 32'h0100_0000);
		quiet = 1'b1;
		for (int n = 0; n < 100; n++) send_word(rand_cmd());
		drop_valid();
	endtask

	initial begin
		kp_m = '0;
		ki_m = '0;
		kd_m = '0;
		alpha_m = Q_ONE;
		limit_m = CLAMP_RST;
		prev_err_m = '0;
		prev_meas_m = '0;
		integ_m = '0;
		dfilt_m = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_directed_extremes();
		test_random_phases();
		test_back_to_back();
		wait_drained();
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/pidsfd_pkg.sv
rtl/pidsfd_div.sv
rtl/pid_step_filtered_derivative.sv
verif/tb_pid_step_filtered_derivative.sv
